### rtl/core/stbs_pkg.sv
// stbs_pkg: shared constants and types for the sorted table search unit.
// No dependencies; imported by every module under rtl/core.
package stbs_pkg;

  localparam int INDEX_W = 10;   // entry_index field width
  localparam int COUNT_W = 11;   // entry_count register width
  localparam int FIELD_W = 32;   // entry_value / search_value field width
  localparam int APB_DW  = 32;   // config data width
  localparam int APB_AW  = 3;    // config byte address width

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // header of one queued operation; the value travels beside it
  typedef struct packed {
    logic               act;
    logic [INDEX_W-1:0] index;
  } op_hdr_t;

endpackage

### rtl/core/stbs_front.sv
// stbs_front: accepts input beats, classifies writes and searches,
// and holds them in a two-entry queue for the back end. Uses stbs_pkg.
module stbs_front
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic        [INDEX_W-1:0]     in_entry_index,
  input  logic signed [FIELD_W-1:0]     in_entry_value,
  input  logic signed [FIELD_W-1:0]     in_search_value,
  output logic                          q_valid,
  input  logic                          q_pop,
  output op_hdr_t                       q_hdr,
  output logic signed [VALUE_WIDTH-1:0] q_value
);

  op_hdr_t                       hdr_q_r [2];
  logic signed [VALUE_WIDTH-1:0] val_q_r [2];
  logic                          wr_ptr_r, wr_ptr_nxt;
  logic                          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;

  logic                          accept, keep, push, pop;
  logic                          idx_in_range;
  op_hdr_t                       hdr_in;
  logic signed [VALUE_WIDTH-1:0] val_in;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;

  // writes past the table end are dropped here
  assign idx_in_range = (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign keep         = (in_action == ACT_SEARCH) || idx_in_range;
  assign push         = accept && keep;

  assign hdr_in.act   = in_action;
  assign hdr_in.index = in_entry_index;
  // sign-extend or cut to the stored word width
  assign val_in = (in_action == ACT_SEARCH) ? VALUE_WIDTH'(in_search_value)
                                            : VALUE_WIDTH'(in_entry_value);

  assign q_valid = (cnt_r != 2'd0);
  assign q_hdr   = hdr_q_r[rd_ptr_r];
  assign q_value = val_q_r[rd_ptr_r];
  assign pop     = q_valid && q_pop;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hdr_q_r[wr_ptr_r] <= hdr_in;
      val_q_r[wr_ptr_r] <= val_in;
    end
  end

endmodule

### rtl/core/stbs_back.sv
// stbs_back: table memory, binary search sequencer and result register.
// Takes operations from stbs_front. Uses stbs_pkg.
module stbs_back
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic        [COUNT_W-1:0]     entry_count,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  op_hdr_t                       q_hdr,
  input  logic signed [VALUE_WIDTH-1:0] q_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];

  logic                          state_r, state_nxt;
  logic [CW-1:0]                 lo_r, lo_nxt;
  logic [CW-1:0]                 hi_r, hi_nxt;
  logic [AW-1:0]                 mid_r, mid_nxt;
  logic signed [VALUE_WIDTH-1:0] target_r, target_nxt;
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;

  logic                          mem_we, rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [CW-1:0]                 n_used;
  logic                          slot_free;

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign slot_free = !out_valid_r || !out_stall;

  // entries in use, clamped to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_used = CW'(TABLE_DEPTH);
    end else begin
      n_used = CW'(entry_count);
    end
  end

  always_comb begin
    logic [CW-1:0] lo_t, hi_t, mid_t;
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    q_pop         = 1'b0;
    lo_t          = lo_r;
    hi_t          = hi_r;
    mid_t         = CW'(mid_r);
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_hdr.act == ACT_WRITE) begin
            mem_we = 1'b1;
            q_pop  = 1'b1;
          end else if (slot_free) begin
            q_pop      = 1'b1;
            target_nxt = q_value;
            lo_nxt     = '0;
            hi_nxt     = n_used;
            if (n_used == '0) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
            end else begin
              mid_nxt   = AW'(n_used >> 1);
              rd_en     = 1'b1;
              state_nxt = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        // rd_data_r holds table_mem[mid_r]; the result slot is free here
        if (rd_data_r == target_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (rd_data_r > target_r) begin
            hi_t = CW'(mid_r);
          end else begin
            lo_t = CW'(mid_r) + CW'(1);
          end
          lo_nxt = lo_t;
          hi_nxt = hi_t;
          if (lo_t < hi_t) begin
            mid_t   = lo_t + ((hi_t - lo_t) >> 1);
            mid_nxt = AW'(mid_t);
            rd_en   = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = mid_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[AW'(q_hdr.index)] <= q_value;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    target_r    <= target_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule

### rtl/core/sorted_table_binary_search_unit.sv
// sorted_table_binary_search_unit: top level with the entry_count register.
// Instantiates stbs_front and stbs_back; uses stbs_pkg.
//
// Usage: software sets entry_count over the APB port (byte address 0),
// then sends beats on the in_ channel. A beat with action 0 writes
// entry_value at entry_index and gives no result; entries must be written
// in nondecreasing order. A beat with action 1 searches the first
// entry_count entries for search_value and gives one out_ beat whose
// found bit says whether it is there. Results leave in query order.
// A write is done by the back end straight from the queue. A search
// over n entries makes at most floor(log2 n) + 1 probes (11 for 1024
// entries), one table read each; the result is registered. An empty
// table answers without a table read. Searches run one at a time.
// A two-beat queue sits between the input and the search sequencer, so
// input beats keep being taken while a search runs or a result waits,
// until the queue is full. A stall on out_ holds the result; the next
// search waits for the slot. Reset clears entry_count, the queue and
// the result valid bit; the table is not cleared, so entries must be
// written before use.
module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic        [APB_AW-1:0]  paddr,
  input  logic        [APB_DW-1:0]  pwdata,
  output logic        [APB_DW-1:0]  prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic        [INDEX_W-1:0] in_entry_index,
  input  logic signed [FIELD_W-1:0] in_entry_value,
  input  logic signed [FIELD_W-1:0] in_search_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found
);

  logic [COUNT_W-1:0]            entry_count_r;
  logic                          cfg_we;
  logic                          q_valid, q_pop;
  op_hdr_t                       q_hdr;
  logic signed [VALUE_WIDTH-1:0] q_value;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[2] == REG_ENTRY_COUNT)
                ? APB_DW'(entry_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  stbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_value (in_search_value),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_hdr           (q_hdr),
    .q_value         (q_value)
  );

  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_count (entry_count_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_hdr       (q_hdr),
    .q_value     (q_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_found   (out_found)
  );

endmodule
